// ----- src/xed_pkg.sv -----
// ============================================================================
// xed_pkg
// Shared types and constants for the XML entity decoder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package xed_pkg;

    // Decoder mode; the unused code behaves as plain text
    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_ENTITY = 2'd1,
        MODE_DROP   = 2'd2
    } mode_t;

    localparam int unsigned MAX_LETTERS = 4;
    localparam int unsigned CNT_W       = 3;

    // Token delimiters
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // Entity names, first letter in the lowest byte
    localparam logic [31:0] NAME_QUOT = {8'h74, 8'h6F, 8'h75, 8'h71};
    localparam logic [31:0] NAME_APOS = {8'h73, 8'h6F, 8'h70, 8'h61};
    localparam logic [23:0] NAME_AMP  = {8'h70, 8'h6D, 8'h61};
    localparam logic [15:0] NAME_LT   = {8'h74, 8'h6C};
    localparam logic [15:0] NAME_GT   = {8'h74, 8'h67};

    // Decoded characters
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // One input word
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    // One result word with its valid flag
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
        logic       status;
    } result_t;

endpackage

`default_nettype wire

// ----- src/xed_in_reg.sv -----
// ============================================================================
// xed_in_reg
// Input register: captures one word from the slave side and holds it until
// the decode stage takes it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module xed_in_reg
    import xed_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  take,
    output logic       held_valid,
    output item_t      held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Accept a new word when empty or when the held word moves on
    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// ----- src/xed_core.sv -----
// ============================================================================
// xed_core
// Decode stage: tracks the entity mode and held letters, and forms at most
// one result for each word it steps.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module xed_core
    import xed_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire item_t item,
    output result_t    res
);

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       letters_reg [MAX_LETTERS];
    logic             letter_we;
    logic [1:0]       letter_idx;
    logic             hit;
    logic [7:0]       hit_ch;
    logic [31:0]      held;

    assign held       = {letters_reg[3], letters_reg[2], letters_reg[1], letters_reg[0]};
    assign letter_idx = count_reg[1:0];

    // Match held letters against the five known names
    always_comb
    begin
        hit    = 1'b1;
        hit_ch = CH_AMP;
        if (count_reg == CNT_W'(4) && held == NAME_QUOT)
        begin
            hit_ch = CH_QUOT;
        end
        else if (count_reg == CNT_W'(4) && held == NAME_APOS)
        begin
            hit_ch = CH_APOS;
        end
        else if (count_reg == CNT_W'(3) && held[23:0] == NAME_AMP)
        begin
            hit_ch = CH_AMP;
        end
        else if (count_reg == CNT_W'(2) && held[15:0] == NAME_LT)
        begin
            hit_ch = CH_LT;
        end
        else if (count_reg == CNT_W'(2) && held[15:0] == NAME_GT)
        begin
            hit_ch = CH_GT;
        end
        else
        begin
            hit = 1'b0;
        end
    end

    // Next mode, letter count and result
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        letter_we  = 1'b0;
        res        = '{valid: 1'b0, ch: item.ch, last: item.last, status: STATUS_OK};
        if (step)
        begin
            unique case (mode_reg)
                MODE_DROP:
                begin
                    if (item.last)
                    begin
                        mode_next = MODE_PLAIN;
                    end
                end
                MODE_ENTITY:
                begin
                    if (item.ch == CH_SEMI && hit)
                    begin
                        res.valid  = 1'b1;
                        res.ch     = hit_ch;
                        mode_next  = MODE_PLAIN;
                        count_next = '0;
                    end
                    else if (item.ch == CH_SEMI || count_reg >= CNT_W'(MAX_LETTERS) ||
                             item.last)
                    begin
                        res        = '{valid: 1'b1, ch: 8'h00, last: 1'b1,
                                       status: STATUS_ERR};
                        mode_next  = item.last ? MODE_PLAIN : MODE_DROP;
                        count_next = '0;
                    end
                    else
                    begin
                        letter_we  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    mode_next = MODE_PLAIN;
                    if (item.ch == CH_AMP && item.last)
                    begin
                        res = '{valid: 1'b1, ch: 8'h00, last: 1'b1, status: STATUS_ERR};
                    end
                    else if (item.ch == CH_AMP)
                    begin
                        mode_next  = MODE_ENTITY;
                        count_next = '0;
                    end
                    else
                    begin
                        res.valid = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    // Store a token letter
    always_ff @(posedge clk)
    begin
        if (letter_we)
        begin
            letters_reg[letter_idx] <= item.ch;
        end
    end

    // Letter count stays within the token limit
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LETTERS))
        else $error("letter count above limit");

    // Letters are held only inside a token
    a_count_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (mode_reg == MODE_ENTITY))
        else $error("letters held outside a token");

    // An error result closes the string with a zero byte
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == STATUS_ERR) |-> (res.last && res.ch == 8'h00))
        else $error("malformed error result");

    // Dropped words give no result
    a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_DROP) |-> !res.valid)
        else $error("result while dropping");

    // An error leaves the decoder outside a token
    a_err_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == STATUS_ERR) |=> (mode_reg != MODE_ENTITY))
        else $error("token still open after error");

endmodule

`default_nettype wire

// ----- src/xed_out_reg.sv -----
// ============================================================================
// xed_out_reg
// Result register: holds one decoded word for the master side and frees
// itself as that word is taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module xed_out_reg
    import xed_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res,
    output logic         free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output logic [7:0]   out_ch,
    output logic         out_last,
    output logic         out_status
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       status_reg;

    // Room for a new word when empty or when the held word leaves now
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ch_reg     <= res.ch;
            last_reg   <= res.last;
            status_reg <= res.status;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ch     = ch_reg;
    assign out_last   = last_reg;
    assign out_status = status_reg;

endmodule

`default_nettype wire

// ----- src/xml_entity_decoder.sv -----
// ============================================================================
// xml_entity_decoder
// Stream decoder for the five predefined XML entities.
// ============================================================================
// Takes one byte per clock on the slave side and gives at most one decoded
// byte per clock on the master side. The result for a word passes through
// the input register, then through the decode logic into the result
// register. Plain bytes pass through; a complete &quot; &apos; &amp; &lt;
// or &gt; becomes its single character. A bad or unfinished token yields
// one error word (tuser = 1, tdata = 0, tlast = 1) and the rest of that
// string is dropped up to its tlast. Throughput is one byte per cycle while
// the master side keeps tready high; the decode stage stalls only when the
// result register is full and not being taken.
`timescale 1ns / 1ps
`default_nettype none

module xml_entity_decoder
    import xed_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // slave side
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] char_in
    input  wire logic       s_tlast,    // string_end
    // master side
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] char_out
    output logic            m_tlast,    // last_of_string
    output logic            m_tuser     // [0] status
);

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    step;
    logic    out_free;
    result_t res;

    assign in_item = '{ch: s_tdata, last: s_tlast};

    // Advance the held word when the result register has room
    assign step = held_valid && out_free;

    xed_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    xed_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (held_item),
        .res   (res)
    );

    xed_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res.valid),
        .res        (res),
        .free       (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_ch     (m_tdata),
        .out_last   (m_tlast),
        .out_status (m_tuser)
    );

endmodule

`default_nettype wire
